// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define MTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define MTS_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`else

`define MTS_ASSERT(label, clk, rst, prop, msg)

`define MTS_ASSERT_IMP(label, clk, rst, cond, prop, msg)

`endif

`endif

// ----- rtl/mts_pkg.sv -----
package mts_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ANT_COUNT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE_BITS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE_LENGTH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_ENABLE = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_START_X     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y     = 3'd7;

  localparam int GRID_REG_W  = 9;
  localparam int COUNT_REG_W = 5;
  localparam int RULE_W      = 17;
  localparam int LEN_W       = 5;
  localparam int START_W     = 8;

  localparam int ANT_INDEX_W = 4;
  localparam int COORD_OUT_W = 8;
  localparam int COLOUR_OUT_W = 8;

  localparam logic [GRID_REG_W-1:0]  GRID_RESET  = 9'd256;
  localparam logic [COUNT_REG_W-1:0] COUNT_RESET = 5'd1;
  localparam logic [RULE_W-1:0]      RULE_RESET  = 17'd2;
  localparam logic [LEN_W-1:0]       LEN_RESET   = 5'd2;
  localparam logic [START_W-1:0]     START_RESET = 8'd128;
  localparam logic [LEN_W-1:0]       LEN_MAX     = 5'd17;
  localparam logic [COUNT_REG_W-1:0] RESULT_LIMIT = 5'd16;

  typedef logic [1:0] heading_t;

  localparam heading_t DIR_Y_INC = 2'd0;
  localparam heading_t DIR_X_DEC = 2'd1;
  localparam heading_t DIR_Y_DEC = 2'd2;
  localparam heading_t DIR_X_INC = 2'd3;

  localparam heading_t HEADING_RESET = DIR_X_DEC;

endpackage

// ----- rtl/multi_ant_turmite_step_top.sv -----
// channel  dir  handshake            payload
// cmd      in   cmd_valid/cmd_stall  advance
// res      out  res_valid/res_stall  ant_index, cell_x, cell_y, new_colour, halted,
//                                    last_of_tick
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// each ant moved goes through fetch, load, the serial remainder unit (colour mod
// rule length), which works through the colour one bit at a time, and the write
// step; a tick takes the request and then moves its ants one after another.
// after reset a clearing pass zeroes the cell memory while cmd_stall is high; cfg
// writes are always taken. the result register is one deep: the write step waits
// while a result is stalled.
`include "assert_macros.svh"

module multi_ant_turmite_step_top #(
  parameter int MAX_COLOUR     = 255,
  parameter int MAX_ANTS_BUILT = 16,
  parameter int GRID_DIM       = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic                               advance,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [mts_pkg::ANT_INDEX_W-1:0]    ant_index,
  output logic [mts_pkg::COORD_OUT_W-1:0]    cell_x,
  output logic [mts_pkg::COORD_OUT_W-1:0]    cell_y,
  output logic [mts_pkg::COLOUR_OUT_W-1:0]   new_colour,
  output logic                               halted,
  output logic                               last_of_tick,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mts_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import mts_pkg::*;

  localparam int CW    = $clog2(GRID_DIM);
  localparam int DW    = (CW + 1 > GRID_REG_W) ? CW + 1 : GRID_REG_W;
  localparam int XW    = (CW > START_W) ? CW : START_W;
  localparam int CLW   = $clog2(MAX_COLOUR + 1);
  localparam int SW    = (CLW > 1) ? $clog2(CLW) : 1;
  localparam int AW    = (MAX_ANTS_BUILT > 1) ? $clog2(MAX_ANTS_BUILT) : 1;
  localparam int CELLS = 1 << (2 * CW);
  localparam int NA    = (MAX_ANTS_BUILT < 16) ? MAX_ANTS_BUILT : 16;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;

  logic [2:0] state;

  // configuration registers
  logic [GRID_REG_W-1:0]  grid_width;
  logic [GRID_REG_W-1:0]  grid_height;
  logic [COUNT_REG_W-1:0] ant_count;
  logic [RULE_W-1:0]      rule_bits;
  logic [LEN_W-1:0]       rule_length;
  logic                   wrap_enable;

  // ant state
  logic [XW-1:0] ant_x [MAX_ANTS_BUILT];
  logic [XW-1:0] ant_y [MAX_ANTS_BUILT];
  heading_t      ant_heading [MAX_ANTS_BUILT];
  logic          stopped;

  // cell memory
  logic [CLW-1:0]    cells [CELLS];
  logic [2*CW-1:0]   clr_addr;
  logic [2*CW-1:0]   rd_addr;
  logic [CLW-1:0]    rd_data;
  logic              mem_we;
  logic [2*CW-1:0]   mem_waddr;
  logic [CLW-1:0]    mem_wdata;

  // per-ant work registers
  logic [AW-1:0]   cur;
  logic [CW-1:0]   x_cur;
  logic [CW-1:0]   y_cur;
  heading_t        head_cur;
  logic [CLW-1:0]  old_col;
  logic [CLW-1:0]  sh;
  logic [LEN_W-1:0] rem;
  logic [SW-1:0]   step;

  logic [DW-1:0]          w_eff, h_eff, w_m1, h_m1;
  logic [COUNT_REG_W-1:0] n_eff;
  logic [LEN_W-1:0]       len_eff;
  logic [DW-1:0]          x_big, y_big, x_sat, y_sat;
  logic [LEN_W:0]         rem_sh, len_ext;
  logic [LEN_W-1:0]       rem_n;
  heading_t               dir;
  logic                   at_edge;
  logic [CW-1:0]          nx, ny;
  logic [CW-1:0]          x_last, y_last;
  logic [CLW-1:0]         col_next;
  logic                   out_free;
  logic                   cmd_take;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;

  // effective configuration
  always_comb begin
    if (grid_width == '0) begin
      w_eff = DW'(1);
    end else if (DW'(grid_width) > DW'(GRID_DIM)) begin
      w_eff = DW'(GRID_DIM);
    end else begin
      w_eff = DW'(grid_width);
    end
    if (grid_height == '0) begin
      h_eff = DW'(1);
    end else if (DW'(grid_height) > DW'(GRID_DIM)) begin
      h_eff = DW'(GRID_DIM);
    end else begin
      h_eff = DW'(grid_height);
    end
    w_m1 = w_eff - DW'(1);
    h_m1 = h_eff - DW'(1);
    n_eff = (ant_count > COUNT_REG_W'(NA)) ? COUNT_REG_W'(NA) : ant_count;
    if (n_eff > RESULT_LIMIT) begin
      n_eff = RESULT_LIMIT;
    end
    if (rule_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (rule_length > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = rule_length;
    end
  end

  // clamp the current ant into the grid
  always_comb begin
    x_big = DW'(ant_x[cur]);
    y_big = DW'(ant_y[cur]);
    x_sat = (x_big >= w_eff) ? w_m1 : x_big;
    y_sat = (y_big >= h_eff) ? h_m1 : y_big;
    rd_addr = {y_sat[CW-1:0], x_sat[CW-1:0]};
  end

  // one restoring remainder step
  always_comb begin
    rem_sh  = {rem, sh[CLW-1]};
    len_ext = {1'b0, len_eff};
    if (rem_sh >= len_ext) begin
      rem_n = LEN_W'(rem_sh - len_ext);
    end else begin
      rem_n = rem_sh[LEN_W-1:0];
    end
  end

  // turn, edge test and step
  always_comb begin
    x_last = w_m1[CW-1:0];
    y_last = h_m1[CW-1:0];
    dir = rule_bits[rem] ? head_cur + 2'd1 : head_cur + 2'd3;
    col_next = (old_col >= CLW'(MAX_COLOUR)) ? '0 : old_col + CLW'(1);
    nx = x_cur;
    ny = y_cur;
    at_edge = 1'b0;
    case (dir)
      DIR_Y_INC: begin
        at_edge = (y_cur == y_last);
        ny = (y_cur == y_last) ? '0 : y_cur + CW'(1);
      end
      DIR_X_DEC: begin
        at_edge = (x_cur == '0);
        nx = (x_cur == '0) ? x_last : x_cur - CW'(1);
      end
      DIR_Y_DEC: begin
        at_edge = (y_cur == '0);
        ny = (y_cur == '0) ? y_last : y_cur - CW'(1);
      end
      default: begin
        at_edge = (x_cur == x_last);
        nx = (x_cur == x_last) ? '0 : x_cur + CW'(1);
      end
    endcase
    at_edge = at_edge && !wrap_enable;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_WRITE && out_free) begin
      mem_we    = 1'b1;
      mem_waddr = {y_cur, x_cur};
      mem_wdata = col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    rd_data <= cells[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      stopped   <= 1'b0;
      res_valid <= 1'b0;
      cur       <= '0;
    end else begin
      if (res_valid && !res_stall && state != S_WRITE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + (2*CW)'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_take && advance && !stopped && n_eff != '0) begin
            cur   <= AW'(int'(n_eff) - 1);
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          x_cur    <= x_sat[CW-1:0];
          y_cur    <= y_sat[CW-1:0];
          head_cur <= ant_heading[cur];
          state    <= S_LOAD;
        end
        S_LOAD: begin
          old_col <= rd_data;
          sh      <= rd_data;
          rem     <= '0;
          step    <= SW'(CLW - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_n;
          sh  <= sh << 1;
          if (step == '0) begin
            state <= S_WRITE;
          end else begin
            step <= step - SW'(1);
          end
        end
        S_WRITE: begin
          if (out_free) begin
            res_valid    <= 1'b1;
            ant_index    <= ANT_INDEX_W'(cur);
            cell_x       <= COORD_OUT_W'(x_cur);
            cell_y       <= COORD_OUT_W'(y_cur);
            new_colour   <= COLOUR_OUT_W'(col_next);
            halted       <= at_edge;
            last_of_tick <= at_edge || (cur == '0);
            if (at_edge) begin
              stopped <= 1'b1;
              state   <= S_IDLE;
            end else if (cur == '0) begin
              state <= S_IDLE;
            end else begin
              cur   <= cur - AW'(1);
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ant registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
      ant_count   <= COUNT_RESET;
      rule_bits   <= RULE_RESET;
      rule_length <= LEN_RESET;
      wrap_enable <= 1'b1;
      for (int i = 0; i < MAX_ANTS_BUILT; i++) begin
        ant_x[i]       <= XW'(START_RESET);
        ant_y[i]       <= XW'(START_RESET);
        ant_heading[i] <= HEADING_RESET;
      end
    end else begin
      if (state == S_WRITE && out_free && !at_edge) begin
        ant_x[cur]       <= XW'(nx);
        ant_y[cur]       <= XW'(ny);
        ant_heading[cur] <= dir;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data[GRID_REG_W-1:0];
          REG_GRID_HEIGHT: grid_height <= cfg_data[GRID_REG_W-1:0];
          REG_ANT_COUNT:   ant_count   <= cfg_data[COUNT_REG_W-1:0];
          REG_RULE_BITS:   rule_bits   <= cfg_data[RULE_W-1:0];
          REG_RULE_LENGTH: rule_length <= cfg_data[LEN_W-1:0];
          REG_WRAP_ENABLE: wrap_enable <= cfg_data[0];
          REG_START_X: begin
            for (int i = 0; i < MAX_ANTS_BUILT; i++) begin
              ant_x[i] <= XW'(cfg_data[START_W-1:0]);
            end
          end
          REG_START_Y: begin
            for (int i = 0; i < MAX_ANTS_BUILT; i++) begin
              ant_y[i] <= XW'(cfg_data[START_W-1:0]);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  `MTS_ASSERT_IMP(a_rem_range, clk, rst, state == S_WRITE, rem < len_eff, "bad remainder")
  `MTS_ASSERT_IMP(a_halt_last, clk, rst, res_valid && halted, last_of_tick, "halt not last")
  `MTS_ASSERT_IMP(a_stop_sticky, clk, rst, !$past(rst) && $past(stopped), stopped, "stop lost")
  `MTS_ASSERT_IMP(a_halt_stops, clk, rst, $rose(res_valid) && halted, stopped, "halt without stop")

endmodule
